// File: rtl/rmeh_pkg.sv
// Shared package for the rotation matrix to heading/pitch/roll unit.
// Holds the datapath widths, status and register codes, pipeline side-band
// structs and the CORDIC arctangent table. Depends on nothing.
package rmeh_pkg;

    localparam int ELEM_BITS         = 24;
    localparam int FRAC_BITS         = ELEM_BITS - 4;
    localparam int ANGLE_BITS        = 16;
    localparam int CORDIC_STAGES_DEF = 18;
    localparam int EPS_BITS          = 16;
    localparam int EPS_RESET         = 168;
    localparam int PADDR_BITS        = 3;
    localparam int PDATA_BITS        = 32;

    // Radicands are 56 bits wide, so each square root takes 28 steps.
    localparam int SQ_W       = 56;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int S_W        = 28;
    localparam int C_W        = 25;
    localparam int X24_W      = 26;
    localparam int DEN_W      = S_W + C_W;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_STEPS  = 26;
    localparam int QUO_W      = DIV_STEPS;
    localparam int RAT_W      = 26;
    localparam int CX_W       = 28;
    localparam int Z_W        = 32;
    localparam int LANES      = 6;
    localparam int ANG_LANES  = 3;
    localparam int NORM_SHIFT = 27;
    localparam int VERT_SHIFT = 3;

    localparam int L_SH  = 0;
    localparam int L_CH  = 1;
    localparam int L_SR  = 2;
    localparam int L_CR  = 3;
    localparam int L_CRV = 4;
    localparam int L_SRV = 5;

    localparam int A_HEAD  = 0;
    localparam int A_PITCH = 1;
    localparam int A_ROLL  = 2;

    typedef enum logic [1:0] {
        STAT_NORMAL = 2'd0,
        STAT_BAD    = 2'd1,
        STAT_VERT   = 2'd2
    } status_t;

    typedef enum logic {
        REG_SCALE_EPS = 1'b0,
        REG_VERT_EPS  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [X24_W-1:0]            x24;
        logic [LANES-1:0]                   neg;
        logic [LANES-1:0][ELEM_BITS-1:0]    mag;
    } sq_side_t;

    typedef struct packed {
        logic signed [X24_W-1:0] x24;
        logic [C_W-1:0]          cp24;
        logic                    bad;
        logic                    vert0;
        logic [LANES-1:0]        neg;
    } dv_side_t;

    typedef struct packed {
        logic                   bad;
        status_t                status;
        logic                   head_on;
        logic [ANG_LANES-1:0]   zero;
    } cr_side_t;

    // Arctangent of 2^-i in units of 2^-32 of a full turn.
    function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] idx);
        logic [Z_W-1:0] a;
        case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            5'd30:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/rmeh_sqrt_cell.sv
// One step of the pipelined integer square root: decides one root bit.
// Depends on rmeh_pkg for the radicand width and step count.
module rmeh_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rmeh_pkg::SQ_W-1:0] rad_in,
    input  logic [rmeh_pkg::SQ_W-1:0] root_in,
    output logic [rmeh_pkg::SQ_W-1:0] rad_out,
    output logic [rmeh_pkg::SQ_W-1:0] root_out
);
    localparam int W  = rmeh_pkg::SQ_W;
    localparam int SH = 2 * (rmeh_pkg::ROOT_STEPS - 1 - STEP);
    localparam logic [W:0] BIT = {{W{1'b0}}, 1'b1} << SH;

    logic [W:0]   trial;
    logic         take;
    logic [W-1:0] rad_next;
    logic [W-1:0] root_next;
    logic [W-1:0] rad_reg;
    logic [W-1:0] root_reg;

    assign trial = {1'b0, root_in} + BIT;
    assign take  = ({1'b0, rad_in} >= trial);

    always_comb
    begin
        if (take)
        begin
            rad_next  = rad_in - trial[W-1:0];
            root_next = (root_in >> 1) + BIT[W-1:0];
        end
        else
        begin
            rad_next  = rad_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign root_out = root_reg;
endmodule

// File: rtl/rmeh_div_cell.sv
// One restoring-division step: yields one quotient bit and passes the
// divisor on. Depends on rmeh_pkg for the remainder and quotient widths.
module rmeh_div_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rmeh_pkg::REM_W-1:0] rem_in,
    input  logic [rmeh_pkg::DEN_W-1:0] den_in,
    input  logic [rmeh_pkg::QUO_W-1:0] quo_in,
    output logic [rmeh_pkg::REM_W-1:0] rem_out,
    output logic [rmeh_pkg::DEN_W-1:0] den_out,
    output logic [rmeh_pkg::QUO_W-1:0] quo_out
);
    localparam int RW = rmeh_pkg::REM_W;
    localparam int DW = rmeh_pkg::DEN_W;
    localparam int QW = rmeh_pkg::QUO_W;

    logic          take;
    logic [RW-1:0] diff;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg;

    assign take = (rem_in >= {1'b0, den_in});
    assign diff = take ? (rem_in - {1'b0, den_in}) : rem_in;
    assign rem_next = {diff[RW-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= {quo_in[QW-2:0], take};
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
endmodule

// File: rtl/rmeh_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its arctangent accumulation.
// Depends on rmeh_pkg for widths and the arctangent table.
module rmeh_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [rmeh_pkg::CX_W-1:0] x_in,
    input  logic signed [rmeh_pkg::CX_W-1:0] y_in,
    input  logic [rmeh_pkg::Z_W-1:0]         z_in,
    output logic signed [rmeh_pkg::CX_W-1:0] x_out,
    output logic signed [rmeh_pkg::CX_W-1:0] y_out,
    output logic [rmeh_pkg::Z_W-1:0]         z_out
);
    localparam int XW = rmeh_pkg::CX_W;
    localparam int ZW = rmeh_pkg::Z_W;
    localparam logic [ZW-1:0] ANG = rmeh_pkg::atan_turn(5'(STEP));

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic [ZW-1:0]        z_reg;

    assign dx = x_in >>> STEP;
    assign dy = y_in >>> STEP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[XW-1])
            begin
                x_reg <= x_in + dy;
                y_reg <= y_in - dx;
                z_reg <= z_in + ANG;
            end
            else
            begin
                x_reg <= x_in - dy;
                y_reg <= y_in + dx;
                z_reg <= z_in - ANG;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// File: rtl/rotation_matrix_to_euler_hpr_unit.sv
// Rotation matrix to heading/pitch/roll: fully pipelined, one transaction per cycle
// while the output is not stalled. Each square-root chain holds 28 cells, each divider
// chain 26 and each CORDIC chain CORDIC_STAGES, plus six glue stages.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (rst_n low, asynchronous) empties the pipeline and sets both thresholds to 168.
// Depends on rmeh_pkg, rmeh_sqrt_cell, rmeh_div_cell and rmeh_cordic_cell.
module rotation_matrix_to_euler_hpr_unit #(
    parameter int CORDIC_STAGES = rmeh_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rmeh_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [rmeh_pkg::PDATA_BITS-1:0]         pwdata,
    output logic [rmeh_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                    pready,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r0c0,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r0c1,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r0c2,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r1c0,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r1c1,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r1c2,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r2c0,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r2c1,
    input  logic signed [rmeh_pkg::ELEM_BITS-1:0]   r2c2,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [rmeh_pkg::ANGLE_BITS-1:0]  heading,
    output logic signed [rmeh_pkg::ANGLE_BITS-1:0]  pitch,
    output logic signed [rmeh_pkg::ANGLE_BITS-1:0]  roll,
    output logic [1:0]                              status
);
    localparam int E     = rmeh_pkg::ELEM_BITS;
    localparam int FRAC  = rmeh_pkg::FRAC_BITS;
    localparam int AB    = rmeh_pkg::ANGLE_BITS;
    localparam int EPSW  = rmeh_pkg::EPS_BITS;
    localparam int SQW   = rmeh_pkg::SQ_W;
    localparam int NSQ   = rmeh_pkg::ROOT_STEPS;
    localparam int SW    = rmeh_pkg::S_W;
    localparam int CW    = rmeh_pkg::C_W;
    localparam int XW24  = rmeh_pkg::X24_W;
    localparam int DW    = rmeh_pkg::DEN_W;
    localparam int RW    = rmeh_pkg::REM_W;
    localparam int NDIV  = rmeh_pkg::DIV_STEPS;
    localparam int QW    = rmeh_pkg::QUO_W;
    localparam int RTW   = rmeh_pkg::RAT_W;
    localparam int XW    = rmeh_pkg::CX_W;
    localparam int ZW    = rmeh_pkg::Z_W;
    localparam int NL    = rmeh_pkg::LANES;
    localparam int NA    = rmeh_pkg::ANG_LANES;
    localparam int LAT   = 60 + CORDIC_STAGES;

    localparam logic signed [E-1:0] ONE_F   = E'(1 << FRAC);
    localparam logic [QW-1:0]       ONE_Q24 = QW'(1 << 24);
    localparam logic [ZW-1:0]       RND     = ZW'(1) << (31 - AB);
    localparam logic [ZW-1:0]       HALF_TURN = ZW'(1) << (ZW - 1);

    // ------------------------------------------------------------------
    // Configuration registers. The APB port never inserts wait states.
    // ------------------------------------------------------------------
    logic [EPSW-1:0] scale_eps_reg;
    logic [EPSW-1:0] vert_eps_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_eps_reg <= EPSW'(rmeh_pkg::EPS_RESET);
            vert_eps_reg  <= EPSW'(rmeh_pkg::EPS_RESET);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                rmeh_pkg::REG_SCALE_EPS: scale_eps_reg <= pwdata[EPSW-1:0];
                rmeh_pkg::REG_VERT_EPS:  vert_eps_reg  <= pwdata[EPSW-1:0];
                default:                 scale_eps_reg <= scale_eps_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            rmeh_pkg::REG_SCALE_EPS: prdata = {{(32 - EPSW){1'b0}}, scale_eps_reg};
            rmeh_pkg::REG_VERT_EPS:  prdata = {{(32 - EPSW){1'b0}}, vert_eps_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage moves in lock step; the pipeline only
    // stops when a finished transaction sits in the output register and
    // the consumer is not taking it.
    // ------------------------------------------------------------------
    logic           adv;
    logic [LAT:1]   vld_reg;

    assign adv       = !vld_reg[LAT] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-1:1], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares of column 0, clamped sine of pitch and its square,
    // and sign/magnitude of every numerator the dividers will need.
    // ------------------------------------------------------------------
    function automatic logic [E-1:0] mag_of(input logic signed [E-1:0] v);
        logic [E-1:0] m;
        m = v[E-1] ? E'(-v) : E'(v);
        return m;
    endfunction

    logic signed [2*E-1:0]    p00;
    logic signed [2*E-1:0]    p10;
    logic signed [2*E-1:0]    p20;
    logic signed [E-1:0]      sp_clamp;
    logic signed [XW24-1:0]   x24_c;
    logic signed [2*XW24-1:0] xsq_c;
    rmeh_pkg::sq_side_t       s1_side;

    logic [2*E-2:0]           sq0_reg;
    logic [2*E-2:0]           sq1_reg;
    logic [2*E-2:0]           sq2_reg;
    logic [48:0]              xsq_reg;
    rmeh_pkg::sq_side_t       s1side_reg;

    assign p00 = r0c0 * r0c0;
    assign p10 = r1c0 * r1c0;
    assign p20 = r2c0 * r2c0;

    always_comb
    begin
        if (r2c1 > ONE_F)
            sp_clamp = ONE_F;
        else if (r2c1 < -ONE_F)
            sp_clamp = -ONE_F;
        else
            sp_clamp = r2c1;
    end

    assign x24_c = {sp_clamp[XW24-5:0], 4'b0000};
    assign xsq_c = x24_c * x24_c;

    always_comb
    begin
        s1_side.x24 = x24_c;
        s1_side.neg[rmeh_pkg::L_SH]  = (r0c1 > 0);
        s1_side.mag[rmeh_pkg::L_SH]  = mag_of(r0c1);
        s1_side.neg[rmeh_pkg::L_CH]  = (r1c1 < 0);
        s1_side.mag[rmeh_pkg::L_CH]  = mag_of(r1c1);
        s1_side.neg[rmeh_pkg::L_SR]  = (r2c0 > 0);
        s1_side.mag[rmeh_pkg::L_SR]  = mag_of(r2c0);
        s1_side.neg[rmeh_pkg::L_CR]  = (r2c2 < 0);
        s1_side.mag[rmeh_pkg::L_CR]  = mag_of(r2c2);
        s1_side.neg[rmeh_pkg::L_CRV] = (r1c0 < 0);
        s1_side.mag[rmeh_pkg::L_CRV] = mag_of(r1c0);
        s1_side.neg[rmeh_pkg::L_SRV] = (r1c2 > 0);
        s1_side.mag[rmeh_pkg::L_SRV] = mag_of(r1c2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq0_reg    <= p00[2*E-2:0];
            sq1_reg    <= p10[2*E-2:0];
            sq2_reg    <= p20[2*E-2:0];
            xsq_reg    <= xsq_c[48:0];
            s1side_reg <= s1_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: radicands. The column length squared is brought to units
    // of 2^-48; the cosine radicand is 1 - sin^2 in the same units.
    // ------------------------------------------------------------------
    logic [2*E-1:0]     col_sum;
    logic [SQW-1:0]     rad_s_reg;
    logic [SQW-1:0]     rad_c_reg;
    rmeh_pkg::sq_side_t sqs_reg [0:NSQ];

    assign col_sum = {1'b0, sq0_reg} + {1'b0, sq1_reg} + {1'b0, sq2_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_s_reg <= {col_sum, {(SQW - 2 * E){1'b0}}};
            rad_c_reg <= SQW'((49'd1 << 48) - xsq_reg);
            sqs_reg[0] <= s1side_reg;
            for (int k = NSQ; k > 0; k--)
            begin
                sqs_reg[k] <= sqs_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Two square-root chains side by side, one root bit per cell.
    // ------------------------------------------------------------------
    logic [SQW-1:0] srad  [0:NSQ];
    logic [SQW-1:0] sroot [0:NSQ];
    logic [SQW-1:0] crad  [0:NSQ];
    logic [SQW-1:0] croot [0:NSQ];

    assign srad[0]  = rad_s_reg;
    assign sroot[0] = '0;
    assign crad[0]  = rad_c_reg;
    assign croot[0] = '0;

    for (genvar gi = 0; gi < NSQ; gi++)
    begin : g_sqrt
        rmeh_sqrt_cell #(.STEP(gi)) u_s (
            .clk      (clk),
            .en       (adv),
            .rad_in   (srad[gi]),
            .root_in  (sroot[gi]),
            .rad_out  (srad[gi+1]),
            .root_out (sroot[gi+1])
        );
        rmeh_sqrt_cell #(.STEP(gi)) u_c (
            .clk      (clk),
            .en       (adv),
            .rad_in   (crad[gi]),
            .root_in  (croot[gi]),
            .rad_out  (crad[gi+1]),
            .root_out (croot[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 31: thresholds, the joint divisor s * cos(pitch) and the
    // initial partial remainders. Normal terms are scaled by 2^52 over the
    // joint divisor, vertical terms by 2^28 over s alone; the first two
    // quotient bits cannot be set unless the ratio saturates.
    // ------------------------------------------------------------------
    logic [SW-1:0]      s24;
    logic [CW-1:0]      cp24;
    logic [DW-1:0]      den_c;
    rmeh_pkg::dv_side_t dv_in;
    logic [RW-1:0]      rem0_reg [0:NL-1];
    logic [DW-1:0]      den0_reg [0:NL-1];
    rmeh_pkg::dv_side_t dvs_reg  [0:NDIV];

    assign s24   = sroot[NSQ][SW-1:0];
    assign cp24  = croot[NSQ][CW-1:0];
    assign den_c = {{CW{1'b0}}, s24} * {{SW{1'b0}}, cp24};

    always_comb
    begin
        dv_in.x24   = sqs_reg[NSQ].x24;
        dv_in.cp24  = cp24;
        dv_in.bad   = (s24 <= {{(SW - EPSW){1'b0}}, scale_eps_reg});
        dv_in.vert0 = (cp24 < {{(CW - EPSW){1'b0}}, vert_eps_reg}) || (cp24 == '0);
        dv_in.neg   = sqs_reg[NSQ].neg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (l == rmeh_pkg::L_CRV || l == rmeh_pkg::L_SRV)
                begin
                    rem0_reg[l] <= RW'(sqs_reg[NSQ].mag[l]) << rmeh_pkg::VERT_SHIFT;
                    den0_reg[l] <= DW'(s24);
                end
                else
                begin
                    rem0_reg[l] <= RW'(sqs_reg[NSQ].mag[l]) << rmeh_pkg::NORM_SHIFT;
                    den0_reg[l] <= den_c;
                end
            end
            dvs_reg[0] <= dv_in;
            for (int k = NDIV; k > 0; k--)
            begin
                dvs_reg[k] <= dvs_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Six divider chains, one quotient bit per cell, most significant first.
    // ------------------------------------------------------------------
    logic [RW-1:0] drem [0:NDIV][0:NL-1];
    logic [DW-1:0] dden [0:NDIV][0:NL-1];
    logic [QW-1:0] dquo [0:NDIV][0:NL-1];

    for (genvar gl = 0; gl < NL; gl++)
    begin : g_div_lane
        assign drem[0][gl] = rem0_reg[gl];
        assign dden[0][gl] = den0_reg[gl];
        assign dquo[0][gl] = '0;
        for (genvar gi = 0; gi < NDIV; gi++)
        begin : g_div
            rmeh_div_cell u_d (
                .clk     (clk),
                .en      (adv),
                .rem_in  (drem[gi][gl]),
                .den_in  (dden[gi][gl]),
                .quo_in  (dquo[gi][gl]),
                .rem_out (drem[gi+1][gl]),
                .den_out (dden[gi+1][gl]),
                .quo_out (dquo[gi+1][gl])
            );
        end
    end

    // ------------------------------------------------------------------
    // Stage 58: saturate each quotient to 1.0, apply the sign, detect the
    // zero sine/cosine pairs and choose the roll terms and the status.
    // ------------------------------------------------------------------
    logic [NL-1:0]              qzero;
    logic signed [RTW-1:0]      rat [0:NL-1];
    logic                       vert_c;
    rmeh_pkg::dv_side_t         dvo;
    rmeh_pkg::cr_side_t         cr_in;
    logic signed [XW-1:0]       lx_reg [0:NA-1];
    logic signed [XW-1:0]       ly_reg [0:NA-1];
    rmeh_pkg::cr_side_t         cr58_reg;

    assign dvo = dvs_reg[NDIV];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            logic [QW-1:0] qs;
            qs = (dquo[NDIV][l] >= ONE_Q24) ? ONE_Q24 : dquo[NDIV][l];
            qzero[l] = (dquo[NDIV][l] == '0);
            rat[l] = dvo.neg[l] ? -$signed(qs) : $signed(qs);
        end
        vert_c = dvo.vert0
              || (qzero[rmeh_pkg::L_SH] && qzero[rmeh_pkg::L_CH])
              || (qzero[rmeh_pkg::L_SR] && qzero[rmeh_pkg::L_CR]);
        cr_in.bad     = dvo.bad;
        cr_in.head_on = !vert_c && !dvo.bad;
        cr_in.zero    = '0;
        if (dvo.bad)
            cr_in.status = rmeh_pkg::STAT_BAD;
        else if (vert_c)
            cr_in.status = rmeh_pkg::STAT_VERT;
        else
            cr_in.status = rmeh_pkg::STAT_NORMAL;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ly_reg[rmeh_pkg::A_HEAD]  <= XW'(rat[rmeh_pkg::L_SH]);
            lx_reg[rmeh_pkg::A_HEAD]  <= XW'(rat[rmeh_pkg::L_CH]);
            ly_reg[rmeh_pkg::A_PITCH] <= XW'(dvo.x24);
            lx_reg[rmeh_pkg::A_PITCH] <= XW'($signed({1'b0, dvo.cp24}));
            ly_reg[rmeh_pkg::A_ROLL]  <= vert_c ? XW'(rat[rmeh_pkg::L_SRV])
                                                : XW'(rat[rmeh_pkg::L_SR]);
            lx_reg[rmeh_pkg::A_ROLL]  <= vert_c ? XW'(rat[rmeh_pkg::L_CRV])
                                                : XW'(rat[rmeh_pkg::L_CR]);
            cr58_reg <= cr_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 59: fold the left half plane onto the right one and flag the
    // origin, whose angle is defined as zero.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx0_reg [0:NA-1];
    logic signed [XW-1:0] cy0_reg [0:NA-1];
    logic [ZW-1:0]        cz0_reg [0:NA-1];
    rmeh_pkg::cr_side_t   crs_reg [0:CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < NA; a++)
            begin
                cx0_reg[a] <= lx_reg[a][XW-1] ? -lx_reg[a] : lx_reg[a];
                cy0_reg[a] <= lx_reg[a][XW-1] ? -ly_reg[a] : ly_reg[a];
                cz0_reg[a] <= lx_reg[a][XW-1] ? HALF_TURN : '0;
            end
            crs_reg[0].bad     <= cr58_reg.bad;
            crs_reg[0].status  <= cr58_reg.status;
            crs_reg[0].head_on <= cr58_reg.head_on;
            for (int a = 0; a < NA; a++)
            begin
                crs_reg[0].zero[a] <= (lx_reg[a] == '0) && (ly_reg[a] == '0);
            end
            for (int k = CORDIC_STAGES; k > 0; k--)
            begin
                crs_reg[k] <= crs_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Three CORDIC chains (heading, pitch, roll) in vectoring mode.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx [0:CORDIC_STAGES][0:NA-1];
    logic signed [XW-1:0] cy [0:CORDIC_STAGES][0:NA-1];
    logic [ZW-1:0]        cz [0:CORDIC_STAGES][0:NA-1];

    for (genvar ga = 0; ga < NA; ga++)
    begin : g_ang_lane
        assign cx[0][ga] = cx0_reg[ga];
        assign cy[0][ga] = cy0_reg[ga];
        assign cz[0][ga] = cz0_reg[ga];
        for (genvar gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_cordic
            rmeh_cordic_cell #(.STEP(gi)) u_r (
                .clk   (clk),
                .en    (adv),
                .x_in  (cx[gi][ga]),
                .y_in  (cy[gi][ga]),
                .z_in  (cz[gi][ga]),
                .x_out (cx[gi+1][ga]),
                .y_out (cy[gi+1][ga]),
                .z_out (cz[gi+1][ga])
            );
        end
    end

    // ------------------------------------------------------------------
    // Output register: round half up to ANGLE_BITS and apply the special
    // cases. It holds the transaction until the consumer takes it.
    // ------------------------------------------------------------------
    logic [ZW-1:0]        zr [0:NA-1];
    logic [AB-1:0]        ang [0:NA-1];
    rmeh_pkg::cr_side_t   cro;
    logic signed [AB-1:0] heading_reg;
    logic signed [AB-1:0] pitch_reg;
    logic signed [AB-1:0] roll_reg;
    rmeh_pkg::status_t    status_reg;

    assign cro = crs_reg[CORDIC_STAGES];

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            zr[a]  = cz[CORDIC_STAGES][a] + RND;
            ang[a] = cro.zero[a] ? '0 : zr[a][ZW-1 -: AB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            heading_reg <= cro.head_on ? $signed(ang[rmeh_pkg::A_HEAD]) : '0;
            pitch_reg   <= cro.bad ? '0 : $signed(ang[rmeh_pkg::A_PITCH]);
            roll_reg    <= cro.bad ? '0 : $signed(ang[rmeh_pkg::A_ROLL]);
            status_reg  <= cro.status;
        end
    end

    assign heading = heading_reg;
    assign pitch   = pitch_reg;
    assign roll    = roll_reg;
    assign status  = status_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rmeh_pkg::STAT_BAD)
        |-> (heading == '0) && (pitch == '0) && (roll == '0))
        else $error("bad matrix transaction carries a non-zero angle");

    a_vert_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rmeh_pkg::STAT_VERT) |-> (heading == '0))
        else $error("vertical fallback transaction carries a non-zero heading");

    a_cfg_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[2] == rmeh_pkg::REG_VERT_EPS)
        |=> (vert_eps_reg == $past(pwdata[EPSW-1:0])))
        else $error("vertical threshold write was lost");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("stalled result changed inside the pipeline");
endmodule
